// File: sv/brb_pkg.sv
// Shared types and codes for the byte ring buffer core.
package brb_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 12;
  localparam int unsigned LEVEL_W  = 11;

  localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH_NOT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CHECKSUM   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DISCARD    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 2'd3;

  localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_PEEK,
    OP_SEARCH,
    OP_SEARCH_NOT,
    OP_CHECKSUM,
    OP_DISCARD,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  endp;
    logic [POS_W-1:0]  cnt;
  } item_t;

endpackage

// File: sv/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/brb_front.sv
// Front end: accept request beats, decode the request type, queue them.
module brb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brb_pkg::REQ_W-1:0]   req_type,
  input  logic [brb_pkg::BYTE_W-1:0]  data_in,
  input  logic [brb_pkg::POS_W-1:0]   position,
  input  logic [brb_pkg::POS_W-1:0]   end_position,
  input  logic [brb_pkg::POS_W-1:0]   discard_count,
  output logic                        q_valid,
  output brb_pkg::item_t              q_item,
  input  logic                        q_pop
);

  brb_pkg::item_t entry [2];
  brb_pkg::item_t item_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    item_in.value = data_in;
    item_in.pos   = position;
    item_in.endp  = end_position;
    item_in.cnt   = discard_count;
    unique case (req_type)
      brb_pkg::REQ_WRITE:      item_in.op = brb_pkg::OP_WRITE;
      brb_pkg::REQ_PEEK:       item_in.op = brb_pkg::OP_PEEK;
      brb_pkg::REQ_SEARCH:     item_in.op = brb_pkg::OP_SEARCH;
      brb_pkg::REQ_SEARCH_NOT: item_in.op = brb_pkg::OP_SEARCH_NOT;
      brb_pkg::REQ_CHECKSUM:   item_in.op = brb_pkg::OP_CHECKSUM;
      brb_pkg::REQ_DISCARD:    item_in.op = brb_pkg::OP_DISCARD;
      default:                 item_in.op = brb_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// File: sv/brb_back.sv
// Back end: run queued requests against the byte store and register results.
module brb_back #(
  parameter int unsigned BUFFER_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  brb_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brb_pkg::STATUS_W-1:0]  status,
  output logic [brb_pkg::BYTE_W-1:0]    data_out,
  output logic [brb_pkg::FOUND_W-1:0]   found_index,
  output logic [brb_pkg::LEVEL_W-1:0]   fill_level,
  output logic [brb_pkg::LEVEL_W-1:0]   free_space
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(BUFFER_DEPTH)) begin
      s = s - SW'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t                      state, state_next;
  brb_pkg::op_t                op, op_next;
  logic [brb_pkg::BYTE_W-1:0]  value, value_next;
  logic [CW-1:0]               held, held_next;
  logic [AW-1:0]               oldest, oldest_next;
  logic [CW-1:0]               limit, limit_next;
  logic [CW-1:0]               chk, chk_next;
  logic [AW-1:0]               chk_slot, chk_slot_next;
  logic [brb_pkg::BYTE_W-1:0]  sum, sum_next;

  logic                        out_free;
  logic                        res_fire;
  logic [brb_pkg::STATUS_W-1:0] res_status;
  logic [brb_pkg::BYTE_W-1:0]  res_data;
  logic [brb_pkg::FOUND_W-1:0] res_found;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [brb_pkg::BYTE_W-1:0]  rdata;
  logic [AW-1:0]               start_slot;
  logic [AW-1:0]               nxt_slot;
  logic [CW-1:0]               disc_n;
  logic                        start_scan;
  logic                        done;
  logic                        last;

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_item.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free   = !out_valid || !out_stall;
  assign start_slot = wrap_add(oldest, CW'(q_item.pos));
  assign nxt_slot   = (chk_slot == AW'(BUFFER_DEPTH - 1)) ? '0 : chk_slot + 1'b1;
  assign last       = ((chk + 1'b1) == limit);

  always_comb begin
    state_next    = state;
    op_next       = op;
    value_next    = value;
    held_next     = held;
    oldest_next   = oldest;
    limit_next    = limit;
    chk_next      = chk;
    chk_slot_next = chk_slot;
    sum_next      = sum;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = wrap_add(oldest, held);
    raddr         = chk_slot;
    res_fire      = 1'b0;
    res_status    = brb_pkg::ST_OK;
    res_data      = '0;
    res_found     = '0;
    start_scan    = 1'b0;
    done          = 1'b0;
    disc_n        = '0;

    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_item.op)
            brb_pkg::OP_WRITE: begin
              we       = 1'b1;
              res_fire = 1'b1;
              if (int'(held) == BUFFER_DEPTH) begin
                oldest_next = wrap_add(oldest, CW'(1));
                res_status  = brb_pkg::ST_OVERWRITE;
              end else begin
                held_next = held + 1'b1;
              end
            end
            brb_pkg::OP_DISCARD: begin
              res_fire = 1'b1;
              if (int'(q_item.cnt) > BUFFER_DEPTH) begin
                res_status = brb_pkg::ST_TOO_BIG;
              end else if (int'(q_item.cnt) > int'(held)) begin
                res_status = brb_pkg::ST_SHORT;
              end
              disc_n = (int'(q_item.cnt) < int'(held)) ? CW'(q_item.cnt) : held;
              if (held != '0) begin
                held_next = held - disc_n;
                if (held_next == '0) begin
                  oldest_next = '0;
                end else begin
                  oldest_next = wrap_add(oldest, disc_n);
                end
              end
            end
            brb_pkg::OP_PEEK: begin
              if (int'(q_item.pos) < int'(held)) begin
                start_scan = 1'b1;
                limit_next = CW'(q_item.pos) + 1'b1;
              end else begin
                res_fire = 1'b1;
              end
            end
            brb_pkg::OP_SEARCH: begin
              if (int'(q_item.pos) < int'(held)) begin
                start_scan = 1'b1;
                limit_next = held;
              end else begin
                res_fire  = 1'b1;
                res_found = brb_pkg::NOT_FOUND;
              end
            end
            brb_pkg::OP_SEARCH_NOT: begin
              if (int'(q_item.pos) > int'(held)) begin
                res_fire  = 1'b1;
                res_found = brb_pkg::NOT_FOUND;
              end else if (int'(q_item.pos) == int'(held)) begin
                res_fire  = 1'b1;
                res_found = brb_pkg::FOUND_W'(held);
              end else begin
                start_scan = 1'b1;
                limit_next = held;
              end
            end
            brb_pkg::OP_CHECKSUM: begin
              if (int'(q_item.pos) < int'(held) && int'(q_item.endp) <= int'(held) &&
                  int'(q_item.endp) > int'(q_item.pos)) begin
                start_scan = 1'b1;
                limit_next = CW'(q_item.endp);
              end else begin
                res_fire = 1'b1;
              end
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
          if (start_scan) begin
            op_next       = q_item.op;
            value_next    = q_item.value;
            raddr         = start_slot;
            chk_next      = CW'(q_item.pos);
            chk_slot_next = start_slot;
            sum_next      = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        case (op)
          brb_pkg::OP_SEARCH: begin
            if (rdata == value) begin
              done      = 1'b1;
              res_found = brb_pkg::FOUND_W'(chk);
            end else if (last) begin
              done      = 1'b1;
              res_found = brb_pkg::NOT_FOUND;
            end
          end
          brb_pkg::OP_SEARCH_NOT: begin
            if (rdata != value) begin
              done      = 1'b1;
              res_found = brb_pkg::FOUND_W'(chk);
            end else if (last) begin
              done      = 1'b1;
              res_found = brb_pkg::FOUND_W'(held);
            end
          end
          default: begin
            res_data = sum + rdata;
            done     = last;
          end
        endcase
        if (done) begin
          if (out_free) begin
            res_fire   = 1'b1;
            state_next = S_IDLE;
          end else begin
            raddr = chk_slot;
          end
        end else begin
          raddr         = nxt_slot;
          chk_slot_next = nxt_slot;
          chk_next      = chk + 1'b1;
          sum_next      = sum + rdata;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    value    <= value_next;
    limit    <= limit_next;
    chk      <= chk_next;
    chk_slot <= chk_slot_next;
    sum      <= sum_next;
    if (out_free && res_fire) begin
      status      <= res_status;
      data_out    <= res_data;
      found_index <= res_found;
      fill_level  <= brb_pkg::LEVEL_W'(held_next);
      free_space  <= brb_pkg::LEVEL_W'(BUFFER_DEPTH - int'(held_next));
    end
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      oldest    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      held   <= held_next;
      oldest <= oldest_next;
      if (out_free) begin
        out_valid <= res_fire;
      end
    end
  end

endmodule

// File: sv/byte_ring_buffer_search_checksum_core.sv
// Top level of the byte ring buffer with search and checksum.
//
// Request channel: in_valid / in_stall with req_type, data_in, position,
// end_position and discard_count; a beat is taken when in_valid is high and
// in_stall low. Result channel: out_valid / out_stall with status, data_out,
// found_index, fill_level and free_space, one result beat per request, in
// request order.
// A two-entry queue sits between the request decoder and the executing
// sequencer, so requests keep arriving while a search or checksum runs.
// Write, discard, unused codes and requests rejected on range finish in the
// sequencer's idle state; the result appears in the cycle after it starts.
// Peek reads its byte through the scan state. Search, search-not and
// checksum read one byte per cycle through the single read port of the
// byte store. While out_valid and out_stall are high the result register
// holds its beat and the sequencer holds once it has a result; a full queue
// sets in_stall.
// Reset empties the buffer, the queue and the result register; the block
// takes requests on the first cycle after reset.
module byte_ring_buffer_search_checksum_core #(
  parameter int unsigned BUFFER_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brb_pkg::REQ_W-1:0]     req_type,
  input  logic [brb_pkg::BYTE_W-1:0]    data_in,
  input  logic [brb_pkg::POS_W-1:0]     position,
  input  logic [brb_pkg::POS_W-1:0]     end_position,
  input  logic [brb_pkg::POS_W-1:0]     discard_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brb_pkg::STATUS_W-1:0]  status,
  output logic [brb_pkg::BYTE_W-1:0]    data_out,
  output logic [brb_pkg::FOUND_W-1:0]   found_index,
  output logic [brb_pkg::LEVEL_W-1:0]   fill_level,
  output logic [brb_pkg::LEVEL_W-1:0]   free_space
);

  logic           q_valid;
  logic           q_pop;
  brb_pkg::item_t q_item;

  brb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .data_in       (data_in),
    .position      (position),
    .end_position  (end_position),
    .discard_count (discard_count),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  brb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .data_out    (data_out),
    .found_index (found_index),
    .fill_level  (fill_level),
    .free_space  (free_space)
  );

endmodule

// File: verif/byte_ring_buffer_search_checksum_core_tb.sv
// Self-checking testbench for the byte ring buffer core with search and checksum.
`timescale 1ns / 100ps

module byte_ring_buffer_search_checksum_core_tb;

  localparam int unsigned DEPTH = 1024;

  typedef logic [brb_pkg::REQ_W-1:0]    req_t;
  typedef logic [brb_pkg::BYTE_W-1:0]   byte_t;
  typedef logic [brb_pkg::POS_W-1:0]    pos_t;
  typedef logic [brb_pkg::STATUS_W-1:0] status_t;
  typedef logic [brb_pkg::FOUND_W-1:0]  found_t;
  typedef logic [brb_pkg::LEVEL_W-1:0]  level_t;

  localparam req_t REQ_SPARE_A = 3'd6;
  localparam req_t REQ_SPARE_B = 3'd7;

  typedef struct {
    status_t status;
    byte_t   data;
    found_t  found;
    level_t  fill;
    level_t  free;
  } ring_result_t;

  int unsigned mismatches = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  class ring_scoreboard;
    byte_t bytes [DEPTH];
    int unsigned head;
    int unsigned held;
    ring_result_t pending [$];

    function new();
      foreach (bytes[k]) bytes[k] = '0;
      head = 0;
      held = 0;
    endfunction

    function byte_t byte_at(int unsigned off);
      return bytes[(head + off) % DEPTH];
    endfunction

    function void note_request(req_t req, byte_t value, pos_t pos, pos_t endp,
                               pos_t cnt);
      ring_result_t r;
      int unsigned i;
      int unsigned n;
      byte_t sum;
      r.status = brb_pkg::ST_OK;
      r.data = '0;
      r.found = '0;
      case (req)
        brb_pkg::REQ_WRITE: begin
          bytes[(head + held) % DEPTH] = value;
          if (held >= DEPTH) begin
            head = (head + 1) % DEPTH;
            r.status = brb_pkg::ST_OVERWRITE;
          end else held++;
        end
        brb_pkg::REQ_PEEK: if (pos < held) r.data = byte_at(pos);
        brb_pkg::REQ_SEARCH: begin
          r.found = brb_pkg::NOT_FOUND;
          for (i = pos; i < held; i++)
            if (byte_at(i) == value) begin
              r.found = found_t'(i);
              break;
            end
        end
        brb_pkg::REQ_SEARCH_NOT: begin
          if (pos > held) r.found = brb_pkg::NOT_FOUND;
          else begin
            i = pos;
            while (i < held && byte_at(i) == value) i++;
            r.found = found_t'(i);
          end
        end
        brb_pkg::REQ_CHECKSUM: begin
          if (pos < held && endp <= held && endp > pos) begin
            sum = '0;
            for (i = pos; i < endp; i++) sum += byte_at(i);
            r.data = sum;
          end
        end
        brb_pkg::REQ_DISCARD: begin
          if (cnt > DEPTH) r.status = brb_pkg::ST_TOO_BIG;
          else if (cnt > held) r.status = brb_pkg::ST_SHORT;
          n = (cnt < held) ? cnt : held;
          if (held > 0) begin
            held -= n;
            if (held == 0) head = 0;
            else head = (head + n) % DEPTH;
          end
        end
        default: ;
      endcase
      r.fill = level_t'(held);
      r.free = level_t'(DEPTH - held);
      pending.push_back(r);
    endfunction

    task check_result(ring_result_t got);
      ring_result_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report("status", int'(got.status), int'(want.status));
      if (got.data !== want.data) report("data_out", int'(got.data), int'(want.data));
      if (got.found !== want.found)
        report("found_index", int'(got.found), int'(want.found));
      if (got.fill !== want.fill) report("fill_level", int'(got.fill), int'(want.fill));
      if (got.free !== want.free) report("free_space", int'(got.free), int'(want.free));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t req_type = '0;
  byte_t data_in = '0;
  pos_t position = '0;
  pos_t end_position = '0;
  pos_t discard_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  status_t status;
  byte_t data_out;
  found_t found_index;
  level_t fill_level;
  level_t free_space;

  ring_scoreboard sb = new();
  bit calm = 1'b0;

  byte_ring_buffer_search_checksum_core #(.BUFFER_DEPTH(DEPTH)) dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{status, data_out, found_index, fill_level, free_space});
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  task automatic send(input req_t req, input byte_t value, input pos_t pos,
                      input pos_t endp, input pos_t cnt);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    data_in <= value;
    position <= pos;
    end_position <= endp;
    discard_count <= cnt;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, value, pos, endp, cnt);
    @(negedge clk);
  endtask

  function automatic pos_t near_offset();
    int unsigned h = sb.held;
    case ($urandom_range(9))
      0: return pos_t'($urandom());
      1: return pos_t'(h);
      2: return pos_t'(h + 1);
      default: return pos_t'($urandom_range(h + 2));
    endcase
  endfunction

  task automatic random_request();
    int unsigned pick = $urandom_range(99);
    pos_t a;
    pos_t b;
    a = near_offset();
    b = near_offset();
    if (pick < 45)
      send(brb_pkg::REQ_WRITE,
           byte_t'($urandom_range(3) == 0 ? $urandom() : $urandom_range(3)),
           a, b, pos_t'($urandom()));
    else if (pick < 55)
      send(brb_pkg::REQ_PEEK, byte_t'($urandom()), a, b, pos_t'($urandom()));
    else if (pick < 67)
      send(brb_pkg::REQ_SEARCH, byte_t'($urandom_range(3)), a, b, pos_t'($urandom()));
    else if (pick < 77)
      send(brb_pkg::REQ_SEARCH_NOT, byte_t'($urandom_range(3)), a, b,
           pos_t'($urandom()));
    else if (pick < 89)
      send(brb_pkg::REQ_CHECKSUM, byte_t'($urandom()), a,
           pos_t'(a + $urandom_range(40)), pos_t'($urandom()));
    else if (pick < 97)
      send(brb_pkg::REQ_DISCARD, byte_t'($urandom()), a, b,
           pos_t'($urandom_range(9) == 0 ? $urandom() : $urandom_range(sb.held / 4 + 2)));
    else
      send(($urandom_range(1) == 0) ? REQ_SPARE_A : REQ_SPARE_B, byte_t'($urandom()),
           pos_t'($urandom()), pos_t'($urandom()), pos_t'($urandom()));
  endtask

  initial begin
    int unsigned lim;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send(brb_pkg::REQ_PEEK, 8'h00, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_SEARCH, 8'h00, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_SEARCH_NOT, 8'h00, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_SEARCH_NOT, 8'h00, 16'd1, 16'd0, 16'd0);
    send(brb_pkg::REQ_CHECKSUM, 8'h00, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_DISCARD, 8'h00, 16'd0, 16'd0, 16'd1);
    send(brb_pkg::REQ_WRITE, 8'hff, 16'hffff, 16'hffff, 16'hffff);
    send(brb_pkg::REQ_WRITE, 8'h00, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_WRITE, 8'ha5, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_PEEK, 8'h00, 16'd2, 16'd0, 16'd0);
    send(brb_pkg::REQ_PEEK, 8'h00, 16'hffff, 16'd0, 16'd0);
    send(brb_pkg::REQ_SEARCH, 8'ha5, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_SEARCH_NOT, 8'hff, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_SEARCH_NOT, 8'ha5, 16'd2, 16'd0, 16'd0);
    send(brb_pkg::REQ_CHECKSUM, 8'h00, 16'd0, 16'd3, 16'd0);
    send(brb_pkg::REQ_CHECKSUM, 8'h00, 16'd2, 16'd1, 16'd0);
    send(REQ_SPARE_A, 8'hff, 16'hffff, 16'hffff, 16'hffff);
    send(REQ_SPARE_B, 8'h00, 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_DISCARD, 8'h00, 16'd0, 16'd0, 16'd1);
    send(brb_pkg::REQ_DISCARD, 8'h00, 16'd0, 16'd0, 16'd1025);
    send(brb_pkg::REQ_DISCARD, 8'h00, 16'd0, 16'd0, 16'hffff);
    // fill past capacity so writes overwrite and the ring wraps
    calm = 1'b1;
    repeat (DEPTH + 3) send(brb_pkg::REQ_WRITE, byte_t'($urandom()), 16'd0, 16'd0, 16'd0);
    calm = 1'b0;
    send(brb_pkg::REQ_SEARCH, byte_t'($urandom()), 16'd0, 16'd0, 16'd0);
    send(brb_pkg::REQ_CHECKSUM, 8'h00, 16'd0, 16'd1024, 16'd0);
    send(brb_pkg::REQ_DISCARD, 8'h00, 16'd0, 16'd0, 16'd1024);
    for (int unsigned k = 0; k < 150; k++) begin
      calm = (k >= 60 && k < 110);
      random_request();
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    lim = 0;
    while (sb.pending.size() != 0 && lim < 200000) begin
      @(posedge clk);
      lim++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: files.f
sv/brb_pkg.sv
sv/brb_ram.sv
sv/brb_front.sv
sv/brb_back.sv
sv/byte_ring_buffer_search_checksum_core.sv
verif/byte_ring_buffer_search_checksum_core_tb.sv
